@@ rtl/map_point_frustum_cull_core_defines.svh @@
// ----------------------------------------------------------------------------
// Map point frustum cull - assertion macros
// Shared concurrent assertion wrappers for the cull core checker.
// ----------------------------------------------------------------------------
`ifndef MAP_POINT_FRUSTUM_CULL_CORE_DEFINES_SVH
`define MAP_POINT_FRUSTUM_CULL_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MPFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MPFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mpfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Map point frustum cull - package
// Register indexes, reject causes, field widths and stage payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package mpfc_pkg;

  localparam int PosW    = 20;
  localparam int NrmW    = 16;
  localparam int TagW    = 16;
  localparam int PixW    = 16;
  localparam int CfgW    = 64;
  localparam int IdxW    = 3;
  localparam int InDataW = 168;
  localparam int OutDataW = 48;
  localparam int QBits   = 17;   // quotient bits kept by the divider
  localparam int MagW    = 54;   // numerator magnitude / remainder width
  localparam int CzW     = 37;   // positive depth width
  localparam int NumStg  = 23;   // 5 front stages, 17 divider stages, output

  typedef enum logic [IdxW-1:0] {
    REG_ROT0   = 3'd0,
    REG_ROT1   = 3'd1,
    REG_ROT2   = 3'd2,
    REG_TRANS  = 3'd3,
    REG_CENTRE = 3'd4,
    REG_INTR   = 3'd5,
    REG_BOUNDS = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_UNUSABLE = 3'd1,
    CAUSE_BEHIND   = 3'd2,
    CAUSE_IMAGE    = 3'd3,
    CAUSE_DIST     = 3'd4,
    CAUSE_ANGLE    = 3'd5
  } cause_t;

  typedef struct packed {
    logic signed [2:0][2:0][35:0] prod;
    logic signed [2:0][33:0]      tsh;
    logic signed [2:0][20:0]      po;
    logic signed [2:0][15:0]      nrm;
    logic [PosW-1:0]              near_l;
    logic [PosW-1:0]              far_l;
    logic                         usable;
    logic [TagW-1:0]              tag;
  } s1_t;

  typedef struct packed {
    logic signed [2:0][37:0] c;
    logic [2:0][40:0]        sq;
    logic signed [2:0][36:0] pn;
    logic [PosW-1:0]         near_l;
    logic [PosW-1:0]         far_l;
    logic                    usable;
    logic [TagW-1:0]         tag;
  } s2_t;

  typedef struct packed {
    logic signed [MagW-1:0] numx;
    logic signed [MagW-1:0] numy;
    logic signed [37:0]     cz;
    logic [41:0]            d2;
    logic signed [38:0]     dot;
    logic [39:0]            near2;
    logic [39:0]            far2;
    logic                   usable;
    logic [TagW-1:0]        tag;
  } s3_t;

  typedef struct packed {
    logic [MagW-1:0] magx;
    logic [MagW-1:0] magy;
    logic            negx;
    logic            negy;
    logic            depth_ok;
    logic [CzW-1:0]  cz;
    logic            dist_fail;
    logic            dot_neg;
    logic [37:0]     dh2;
    logic [37:0]     dhdl;
    logic [37:0]     dl2;
    logic [41:0]     d2;
    logic            usable;
    logic [TagW-1:0] tag;
  } s4_t;

  typedef struct packed {
    logic [MagW-1:0]  rx;
    logic [MagW-1:0]  ry;
    logic [QBits-1:0] qx;
    logic [QBits-1:0] qy;
    logic [CzW-1:0]   cz;
    logic             negx;
    logic             negy;
    logic             ovfx;
    logic             ovfy;
    logic             usable;
    logic             depth_ok;
    logic             dist_fail;
    logic             angle_fail;
    logic [TagW-1:0]  tag;
  } div_t;

endpackage

`default_nettype wire

@@ rtl/map_point_frustum_cull_core.sv @@
// Pipeline: 5 arithmetic stages, 17 divider stages at one quotient bit each,
// one output register.
// Throughput: one point per cycle while out_tready holds; each stage holds its item only while the
// stage after it is full and stalled, so bubbles are squeezed out.
// Reset (rst_n low, synchronous): pipeline emptied, rotation set to identity,
// all other configuration registers cleared.
`default_nettype none

// ----------------------------------------------------------------------------
// Map point frustum cull core
// Camera transform, pinhole projection with pipelined division, image,
// distance and viewing angle tests for one map point per cycle unless stalled.
// ----------------------------------------------------------------------------
module map_point_frustum_cull_core
  import mpfc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [IdxW-1:0]     cfg_index,
  input  wire logic [CfgW-1:0]     cfg_wdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // pos_x, pos_y, pos_z, near_limit, far_limit, normal_x, normal_y,
  // normal_z, point_tag, zero pad
  input  wire logic [InDataW-1:0]  in_tdata,
  // usable
  input  wire logic                in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // pixel_u, pixel_v, result_tag
  output logic [OutDataW-1:0]      out_tdata,
  // accepted, reject_cause
  output logic [3:0]               out_tuser
);

  // configuration
  logic [47:0] rot_r [3];
  logic [59:0] trans_r;
  logic [59:0] centre_r;
  logic [63:0] intr_r;
  logic [63:0] bounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= 48'd16384;
      rot_r[1] <= 48'd16384 << 16;
      rot_r[2] <= 48'd16384 << 32;
      trans_r  <= '0;
      centre_r <= '0;
      intr_r   <= '0;
      bounds_r <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_ROT0:   rot_r[0] <= cfg_wdata[47:0];
        REG_ROT1:   rot_r[1] <= cfg_wdata[47:0];
        REG_ROT2:   rot_r[2] <= cfg_wdata[47:0];
        REG_TRANS:  trans_r  <= cfg_wdata[59:0];
        REG_CENTRE: centre_r <= cfg_wdata[59:0];
        REG_INTR:   intr_r   <= cfg_wdata;
        REG_BOUNDS: bounds_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage flow control
  logic [NumStg-1:0] v_r;
  logic [NumStg-1:0] en;

  always_comb begin
    en[NumStg-1] = !v_r[NumStg-1] || out_tready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: rotation products, offset from camera centre
  logic signed [2:0][19:0] pin;
  s1_t s1_nxt, s1_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pin[j] = in_tdata[20*j +: 20];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_nxt.prod[i][j] = 36'($signed(rot_r[i][16*j +: 16])) * 36'($signed(pin[j]));
      end
      s1_nxt.tsh[i] = $signed({trans_r[20*i +: 20], 14'b0});
      s1_nxt.po[i]  = 21'($signed(pin[i])) - 21'($signed(centre_r[20*i +: 20]));
      s1_nxt.nrm[i] = in_tdata[100 + 16*i +: 16];
    end
    s1_nxt.near_l = in_tdata[79:60];
    s1_nxt.far_l  = in_tdata[99:80];
    s1_nxt.usable = in_tuser;
    s1_nxt.tag    = in_tdata[163:148];
  end

  always_ff @(posedge clk) begin
    if (en[0]) s1_r <= s1_nxt;
  end

  // stage 2: camera coordinates, squares and normal products
  s2_t s2_nxt, s2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_nxt.c[i] = 38'($signed(s1_r.prod[i][0])) + 38'($signed(s1_r.prod[i][1]))
                  + 38'($signed(s1_r.prod[i][2])) + 38'($signed(s1_r.tsh[i]));
      s2_nxt.sq[i] = 41'($signed(s1_r.po[i])) * 41'($signed(s1_r.po[i]));
      s2_nxt.pn[i] = 37'($signed(s1_r.po[i])) * 37'($signed(s1_r.nrm[i]));
    end
    s2_nxt.near_l = s1_r.near_l;
    s2_nxt.far_l  = s1_r.far_l;
    s2_nxt.usable = s1_r.usable;
    s2_nxt.tag    = s1_r.tag;
  end

  always_ff @(posedge clk) begin
    if (en[1]) s2_r <= s2_nxt;
  end

  // stage 3: projection numerators, distance and dot sums, window squares
  s3_t s3_nxt, s3_r;

  always_comb begin
    s3_nxt.numx  = MagW'($signed({1'b0, intr_r[15:0]})) * MagW'($signed(s2_r.c[0]));
    s3_nxt.numy  = MagW'($signed({1'b0, intr_r[31:16]})) * MagW'($signed(s2_r.c[1]));
    s3_nxt.cz    = s2_r.c[2];
    s3_nxt.d2    = 42'(s2_r.sq[0]) + 42'(s2_r.sq[1]) + 42'(s2_r.sq[2]);
    s3_nxt.dot   = 39'($signed(s2_r.pn[0])) + 39'($signed(s2_r.pn[1]))
                 + 39'($signed(s2_r.pn[2]));
    s3_nxt.near2 = 40'(s2_r.near_l) * 40'(s2_r.near_l);
    s3_nxt.far2  = 40'(s2_r.far_l) * 40'(s2_r.far_l);
    s3_nxt.usable = s2_r.usable;
    s3_nxt.tag    = s2_r.tag;
  end

  always_ff @(posedge clk) begin
    if (en[2]) s3_r <= s3_nxt;
  end

  // stage 4: magnitudes, depth and window tests, split dot square
  s4_t s4_nxt, s4_r;
  logic [18:0] dh, dl;

  always_comb begin
    dh = s3_r.dot[37:19];
    dl = s3_r.dot[18:0];
    s4_nxt.negx = s3_r.numx[MagW-1];
    s4_nxt.negy = s3_r.numy[MagW-1];
    s4_nxt.magx = s3_r.numx[MagW-1] ? MagW'(-s3_r.numx) : MagW'(s3_r.numx);
    s4_nxt.magy = s3_r.numy[MagW-1] ? MagW'(-s3_r.numy) : MagW'(s3_r.numy);
    s4_nxt.depth_ok = !s3_r.cz[37] && (s3_r.cz != '0);
    s4_nxt.cz       = s3_r.cz[CzW-1:0];
    s4_nxt.dist_fail = ({2'b0, s3_r.near2} > s3_r.d2) || (s3_r.d2 > {2'b0, s3_r.far2});
    s4_nxt.dot_neg  = s3_r.dot[38];
    s4_nxt.dh2      = 38'(dh) * 38'(dh);
    s4_nxt.dhdl     = 38'(dh) * 38'(dl);
    s4_nxt.dl2      = 38'(dl) * 38'(dl);
    s4_nxt.d2       = s3_r.d2;
    s4_nxt.usable   = s3_r.usable;
    s4_nxt.tag      = s3_r.tag;
  end

  always_ff @(posedge clk) begin
    if (en[3]) s4_r <= s4_nxt;
  end

  // stage 5: angle test, quotient range check, divider load
  div_t div_r [QBits+1];
  div_t div0_nxt;
  logic [75:0] dot2;
  logic [MagW-1:0] cz_top;

  always_comb begin
    // dot^2 compared against d2 * 2^26 (dist scaled to Q.14, halved)
    dot2 = {s4_r.dh2, 38'b0} + {18'b0, s4_r.dhdl, 20'b0} + {38'b0, s4_r.dl2};
    cz_top = {s4_r.cz, 17'b0};
    div0_nxt.rx   = s4_r.magx;
    div0_nxt.ry   = s4_r.magy;
    div0_nxt.qx   = '0;
    div0_nxt.qy   = '0;
    div0_nxt.cz   = s4_r.cz;
    div0_nxt.negx = s4_r.negx;
    div0_nxt.negy = s4_r.negy;
    div0_nxt.ovfx = s4_r.magx >= cz_top;
    div0_nxt.ovfy = s4_r.magy >= cz_top;
    div0_nxt.usable     = s4_r.usable;
    div0_nxt.depth_ok   = s4_r.depth_ok;
    div0_nxt.dist_fail  = s4_r.dist_fail;
    div0_nxt.angle_fail = s4_r.dot_neg || (dot2 < {8'b0, s4_r.d2, 26'b0});
    div0_nxt.tag        = s4_r.tag;
  end

  always_ff @(posedge clk) begin
    if (en[4]) div_r[0] <= div0_nxt;
  end

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar d = 0; d < QBits; d++) begin : g_div
    localparam int K = QBits - 1 - d;
    div_t        dn;
    logic [MagW-1:0] dsh;

    always_comb begin
      dn  = div_r[d];
      dsh = MagW'(div_r[d].cz) << K;
      if (div_r[d].rx >= dsh) begin
        dn.rx    = div_r[d].rx - dsh;
        dn.qx[K] = 1'b1;
      end
      if (div_r[d].ry >= dsh) begin
        dn.ry    = div_r[d].ry - dsh;
        dn.qy[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[5+d]) div_r[d+1] <= dn;
    end
  end

  // output stage: floor correction, image bounds, cause selection
  div_t fin;
  logic signed [QBits+1:0] qsx, qsy, u, v;
  logic img_ok;
  cause_t cause;
  logic [OutDataW-1:0] odata_nxt, odata_r;
  logic [3:0] ouser_nxt, ouser_r;

  always_comb begin
    fin = div_r[QBits];
    qsx = fin.negx ? -$signed({2'b0, fin.qx}) - ((fin.rx != '0) ? 19'sd1 : 19'sd0)
                   : $signed({2'b0, fin.qx});
    qsy = fin.negy ? -$signed({2'b0, fin.qy}) - ((fin.ry != '0) ? 19'sd1 : 19'sd0)
                   : $signed({2'b0, fin.qy});
    u = qsx + $signed({3'b0, intr_r[47:32]});
    v = qsy + $signed({3'b0, intr_r[63:48]});
    img_ok = !fin.ovfx && !fin.ovfy
          && (u >= $signed({3'b0, bounds_r[15:0]}))
          && (u <  $signed({3'b0, bounds_r[31:16]}))
          && (v >= $signed({3'b0, bounds_r[47:32]}))
          && (v <  $signed({3'b0, bounds_r[63:48]}));
    if (!fin.usable)        cause = CAUSE_UNUSABLE;
    else if (!fin.depth_ok) cause = CAUSE_BEHIND;
    else if (!img_ok)       cause = CAUSE_IMAGE;
    else if (fin.dist_fail) cause = CAUSE_DIST;
    else if (fin.angle_fail) cause = CAUSE_ANGLE;
    else                    cause = CAUSE_NONE;
    odata_nxt[15:0]  = (cause == CAUSE_NONE) ? u[15:0] : '0;
    odata_nxt[31:16] = (cause == CAUSE_NONE) ? v[15:0] : '0;
    odata_nxt[47:32] = fin.tag;
    ouser_nxt = {cause, cause == CAUSE_NONE};
  end

  always_ff @(posedge clk) begin
    if (en[NumStg-1]) begin
      odata_r <= odata_nxt;
      ouser_r <= ouser_nxt;
    end
  end

  assign out_tvalid = v_r[NumStg-1];
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

`default_nettype wire

@@ rtl/mpfc_checker.sv @@
`default_nettype none

// ----------------------------------------------------------------------------
// Map point frustum cull - port checker
// Watches the top-level result channel; bound to the core below.
// ----------------------------------------------------------------------------
`include "map_point_frustum_cull_core_defines.svh"

module mpfc_checker
  import mpfc_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata,
  input wire logic [3:0]          out_tuser
);

  `MPFC_ASSERT_NOW(a_accept_cause, out_tvalid, out_tuser[0] == (out_tuser[3:1] == CAUSE_NONE), "accept flag disagrees with cause")
  `MPFC_ASSERT_NOW(a_reject_zero_pix, out_tvalid && !out_tuser[0], out_tdata[31:0] == '0, "rejected point carries pixels")
  `MPFC_ASSERT_NOW(a_cause_range, out_tvalid, out_tuser[3:1] <= CAUSE_ANGLE, "reject cause out of range")
  `MPFC_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind map_point_frustum_cull_core mpfc_checker u_mpfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Map point frustum cull - testbench
// Drives map points through the cull core under several camera settings,
// predicts accept flag, reject cause and pixel coordinates per point, and
// checks every result in order under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import mpfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  cause;
    logic [15:0] u;
    logic [15:0] v;
    logic [15:0] tag;
  } cull_res_t;

  typedef struct {
    logic signed [19:0] p[3];
    logic [19:0]        near_l;
    logic [19:0]        far_l;
    logic signed [15:0] n[3];
    logic               usable;
    logic [15:0]        tag;
  } map_point_t;

  // Camera model and queue of pending cull decisions
  class cull_scoreboard;
    logic [47:0] rot[3];
    logic [59:0] trans;
    logic [59:0] centre;
    logic [63:0] intr;
    logic [63:0] bounds;
    cull_res_t   pending[$];
    int          errors;

    function void reset_regs();
      rot[0] = 48'd16384;
      rot[1] = 48'd16384 << 16;
      rot[2] = 48'd16384 << 32;
      trans = '0; centre = '0; intr = '0; bounds = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] val);
      case (idx)
        REG_ROT0:   rot[0] = val[47:0];
        REG_ROT1:   rot[1] = val[47:0];
        REG_ROT2:   rot[2] = val[47:0];
        REG_TRANS:  trans = val[59:0];
        REG_CENTRE: centre = val[59:0];
        REG_INTR:   intr = val;
        REG_BOUNDS: bounds = val;
        default: ;
      endcase
    endfunction

    static function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && ((n < 0) != (d < 0))) q = q - 1;
      return q;
    endfunction

    function void note_point(map_point_t pt);
      longint c[3];
      longint po;
      longint u, v, dot;
      logic signed [127:0] d2, tw2;
      cull_res_t r;
      cause_t cause;
      u = 0; v = 0;
      for (int i = 0; i < 3; i++) begin
        c[i] = longint'($signed(trans[i*20 +: 20])) * 16384;
        for (int j = 0; j < 3; j++)
          c[i] += longint'($signed(rot[i][j*16 +: 16])) * longint'(pt.p[j]);
      end
      cause = CAUSE_NONE;
      if (!pt.usable) cause = CAUSE_UNUSABLE;
      else if (c[2] <= 0) cause = CAUSE_BEHIND;
      else begin
        u = floor_quot(longint'(intr[15:0]) * c[0], c[2]) + longint'(intr[47:32]);
        v = floor_quot(longint'(intr[31:16]) * c[1], c[2]) + longint'(intr[63:48]);
        if (!(u >= longint'(bounds[15:0]) && u < longint'(bounds[31:16]) &&
              v >= longint'(bounds[47:32]) && v < longint'(bounds[63:48])))
          cause = CAUSE_IMAGE;
        else begin
          d2 = 0; dot = 0;
          for (int i = 0; i < 3; i++) begin
            po = longint'(pt.p[i]) - longint'($signed(centre[i*20 +: 20]));
            d2 += po * po;
            dot += po * longint'(pt.n[i]);
          end
          if (d2 < longint'(pt.near_l) * longint'(pt.near_l) ||
              d2 > longint'(pt.far_l) * longint'(pt.far_l))
            cause = CAUSE_DIST;
          else if (dot < 0) cause = CAUSE_ANGLE;
          else begin
            // (2*dot)^2 >= d2 * 2^28
            tw2 = 128'(2 * dot) * 128'(2 * dot);
            if (tw2 < (d2 <<< 28)) cause = CAUSE_ANGLE;
          end
        end
      end
      r.accepted = (cause == CAUSE_NONE);
      r.cause = cause;
      r.u = r.accepted ? u[15:0] : 16'd0;
      r.v = r.accepted ? v[15:0] : 16'd0;
      r.tag = pt.tag;
      pending = {pending, r};
    endfunction

    function void check_result(cull_res_t act);
      cull_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.accepted !== e.accepted) begin
        $display("%0t: accepted exp %0d got %0d", $realtime, e.accepted, act.accepted);
        errors++;
      end
      if (act.cause !== e.cause) begin
        $display("%0t: cause exp %0d got %0d", $realtime, e.cause, act.cause);
        errors++;
      end
      if (act.u !== e.u) begin
        $display("%0t: pixel_u exp %h got %h", $realtime, e.u, act.u);
        errors++;
      end
      if (act.v !== e.v) begin
        $display("%0t: pixel_v exp %h got %h", $realtime, e.v, act.v);
        errors++;
      end
      if (act.tag !== e.tag) begin
        $display("%0t: tag exp %h got %h", $realtime, e.tag, act.tag);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [IdxW-1:0]     cfg_index = '0;
  logic [CfgW-1:0]     cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [3:0]          out_tuser;

  cull_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  logic [15:0] tag_ctr = '0;

  map_point_frustum_cull_core dut (.*);

  always #5 clk = ~clk;

  // result sampling and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result({out_tuser[0], out_tuser[3:1], out_tdata[15:0],
                         out_tdata[31:16], out_tdata[47:32]});
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 5000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // sink stall pattern, mode changes now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) == 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_cfg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // inputs change only at negedge; send waits for the accepting posedge
  task automatic send_point(map_point_t pt);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= pt.usable;
    in_tdata <= {4'd0, pt.tag, pt.n[2], pt.n[1], pt.n[0], pt.far_l, pt.near_l,
                 pt.p[2], pt.p[1], pt.p[0]};
    do @(posedge clk); while (!in_tready);
    sb.note_point(pt);
  endtask

  task automatic pause_source(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // mostly points near the camera's view, sometimes anything
  function automatic map_point_t rand_point();
    map_point_t pt;
    int wide;
    wide = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < 3; i++) begin
      pt.p[i] = wide ? 20'($urandom) : 20'($signed($urandom_range(0, 8191)) - 4096);
      pt.n[i] = wide ? 16'($urandom) : 16'($signed($urandom_range(0, 32767)) - 8192);
    end
    if (!wide) pt.p[2] = 20'($urandom_range(256, 16383));
    pt.near_l = wide ? 20'($urandom) : 20'($urandom_range(0, 2048));
    pt.far_l = wide ? 20'($urandom) : 20'($urandom_range(2048, 1048575));
    pt.usable = ($urandom_range(0, 9) != 0);
    pt.tag = tag_ctr;
    tag_ctr++;
    return pt;
  endfunction

  task automatic random_phase(int count);
    int burst;
    map_point_t pt;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && count > 0; k++) begin
        pt = rand_point();
        send_point(pt);
        count--;
      end
      if ($urandom_range(0, 2) != 0) pause_source($urandom_range(1, 12));
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic rand_camera();
    int a;
    a = $urandom_range(0, 2);
    // small random perturbations of identity, or fully random rows
    for (int i = 0; i < 3; i++)
      write_cfg(reg_idx_t'(i), (a == 2) ? 64'({$urandom, $urandom}) :
        (48'(16'($signed($urandom_range(0, 2047)) - 1024)) |
         (48'(16'($signed($urandom_range(0, 2047)) - 1024)) << 16) |
         (48'(16'($signed($urandom_range(0, 2047)) - 1024)) << 32)) +
        (48'd16384 << (16 * i)));
    write_cfg(REG_TRANS, {4'd0, 20'($urandom_range(0, 2047)),
                          20'($urandom_range(0, 1023)), 20'($urandom_range(0, 1023))});
    write_cfg(REG_CENTRE, (a == 1) ? 64'({$urandom, $urandom}) & 64'hFFF_FFFF_FFFF_FFFF :
                          {4'd0, 20'($urandom_range(0, 511)), 20'($urandom_range(0, 511)),
                           20'($urandom_range(0, 511))});
    write_cfg(REG_INTR, {16'($urandom_range(0, 8000)), 16'($urandom_range(0, 8000)),
                         16'($urandom_range(0, 12000)), 16'($urandom_range(0, 12000))});
    write_cfg(REG_BOUNDS, {16'($urandom_range(8000, 16000)), 16'($urandom_range(0, 500)),
                           16'($urandom_range(10000, 20000)), 16'($urandom_range(0, 500))});
  endtask

  initial begin
    map_point_t pt;
    sb.reset_regs();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // points before any write: reset camera, zero intrinsics/bounds
    pt = rand_point(); pt.p[2] = 20'sd256; send_point(pt);
    pt = rand_point(); pt.p[2] = 20'sd0; send_point(pt);
    @(negedge clk); in_tvalid <= 1'b0;
    drain();

    // directed camera: identity, 640x480 style
    write_cfg(REG_TRANS, 64'd0);
    write_cfg(REG_CENTRE, 64'd0);
    write_cfg(REG_INTR, {16'd3840, 16'd5120, 16'd8000, 16'd8000});
    write_cfg(REG_BOUNDS, {16'd7680, 16'd0, 16'd10240, 16'd0});
    // accepted: straight ahead, normal toward the point
    pt = rand_point();
    pt.p = '{20'sd0, 20'sd0, 20'sd2560}; pt.n = '{16'sd0, 16'sd0, 16'sd16384};
    pt.near_l = 20'd0; pt.far_l = 20'hFFFFF; pt.usable = 1'b1; send_point(pt);
    pt.usable = 1'b0; send_point(pt);                     // unusable
    pt.usable = 1'b1; pt.p[2] = 20'sd0; send_point(pt);   // zero depth
    pt.p[2] = -20'sd524288; send_point(pt);               // behind
    pt.p = '{20'sd524287, 20'sd0, 20'sd256}; send_point(pt);  // outside image
    pt.p = '{20'sd0, 20'sd0, 20'sd2560}; pt.near_l = 20'd4000; send_point(pt);
    pt.near_l = 20'd2560; pt.far_l = 20'd2560; send_point(pt); // on both limits
    pt.near_l = 20'd0; pt.far_l = 20'd100; send_point(pt);    // too far
    pt.far_l = 20'hFFFFF; pt.n = '{16'sd0, 16'sd0, -16'sd32768}; send_point(pt);
    pt.n = '{16'sd32767, 16'sd0, 16'sd0}; send_point(pt);     // dot zero
    pt.n = '{16'sd0, 16'sd0, 16'sd8192}; send_point(pt);      // exactly half
    pt.n = '{16'sd0, 16'sd0, 16'sd8191}; send_point(pt);
    pt.p = '{-20'sd524288, -20'sd524288, 20'sd524287}; pt.n = '{-16'sd32768, -16'sd32768,
      16'sd32767}; pt.near_l = 20'hFFFFF; pt.tag = 16'hFFFF; send_point(pt);
    pt.tag = 16'h0000; pt.near_l = 20'd0; send_point(pt);
    @(negedge clk); in_tvalid <= 1'b0;
    drain();

    // min >= max bounds and near > far
    write_cfg(REG_BOUNDS, {16'd0, 16'd0, 16'hFFFF, 16'hFFFF});
    pt.p = '{20'sd0, 20'sd0, 20'sd2560}; send_point(pt);
    @(negedge clk); in_tvalid <= 1'b0;
    drain();
    write_cfg(REG_BOUNDS, {16'hFFFF, 16'd0, 16'hFFFF, 16'd0});
    pt.near_l = 20'd3000; pt.far_l = 20'd2000; send_point(pt);
    @(negedge clk); in_tvalid <= 1'b0;
    drain();

    // extreme register values
    write_cfg(REG_ROT0, 64'h8000_7FFF_8000);
    write_cfg(REG_ROT1, 64'h7FFF_8000_7FFF);
    write_cfg(REG_ROT2, 64'h7FFF_7FFF_7FFF);
    write_cfg(REG_TRANS, 64'h7FFF_FFFF_FFFF_FFFF);
    write_cfg(REG_CENTRE, 64'hF800_0000_0000_0000);
    write_cfg(REG_INTR, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_BOUNDS, 64'hFFFF_0000_FFFF_0000);
    random_phase(60);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      rand_camera();
      random_phase(300);
      drain();
    end

    in_tvalid <= 1'b0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
